[design/asta_pkg.sv]
package asta_pkg;

	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_FREE    = 3'd1;
	localparam logic [2:0] OP_EXACT   = 3'd2;
	localparam logic [2:0] OP_POOL    = 3'd3;
	localparam logic [2:0] OP_OBSERVE = 3'd4;
	localparam logic [2:0] OP_INIT    = 3'd5;

	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_ALLOC_SIZE  = 3'd1;
	localparam logic [2:0] ERR_LOOKUP_MISS = 3'd2;
	localparam logic [2:0] ERR_FREE_SIZE   = 3'd3;
	localparam logic [2:0] ERR_FREE_MISS   = 3'd4;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ARENA_START    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_METADATA_START = 1'b1;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] address;
		logic [63:0] size;
		logic [31:0] event_code;
	} asta_in_t;

	typedef struct packed {
		logic [63:0] result_address;
		logic        found;
		logic [2:0]  error_code;
		logic [31:0] grants_total;
		logic [31:0] releases_total;
		logic [63:0] checksum;
	} asta_out_t;

	// Multiply by 13 as 8 + 4 + 1.
	function automatic logic [63:0] mul13(input logic [63:0] v);
		return (v << 3) + (v << 2) + v;
	endfunction

	// Multiply by 33 as 32 + 1.
	function automatic logic [63:0] mul33(input logic [63:0] v);
		return (v << 5) + v;
	endfunction

endpackage

[design/asta_slot_ram.sv]
module asta_slot_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[design/asta_ctrl.sv]
module asta_ctrl #(
	parameter int unsigned     SLOTS        = 32,
	parameter longint unsigned REGION_BYTES = 64'd33554432,
	parameter longint unsigned ARENA_BYTES  = 64'd1048576,
	parameter longint unsigned POOL_BYTES   = 64'd16384,
	parameter int unsigned     IW           = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  asta_pkg::asta_in_t  req,
	output logic                done,
	output asta_pkg::asta_out_t rsp,
	input  logic [63:0]         arena_start,
	input  logic [63:0]         metadata_start,
	output logic                mem_we,
	output logic [IW-1:0]       mem_waddr,
	output logic [63:0]         mem_wdata,
	output logic [IW-1:0]       mem_raddr,
	input  logic [63:0]         mem_rdata
);
	import asta_pkg::*;

	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam logic [63:0] ARENA64   = 64'(ARENA_BYTES);
	localparam logic [63:0] REGION64  = 64'(REGION_BYTES);
	localparam logic [63:0] POOL_LOW  = 64'(POOL_BYTES) - 64'd1;
	localparam logic [31:0] ARENA32   = 32'(ARENA_BYTES);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LOC, S_TERM, S_FIN} state_t;

	state_t      state_q;
	logic [2:0]  op_q;
	logic [63:0] key_q;
	logic [63:0] size13_q;
	logic [31:0] code_q;
	logic        size_ok_q;

	logic [CW-1:0] rd_ptr_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          live_s1;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [63:0]   hit_base_q;
	logic [63:0]   diff_q;
	logic [31:0]   hit_ofs_q;
	logic [63:0]   loc_q;
	logic [63:0]   term_q;

	logic [SLOTS-1:0] live_q;
	logic [SLOTS-1:0] assigned_q;
	logic [63:0]      bump_q;
	logic [31:0]      grant_q;
	logic [31:0]      release_q;
	logic [63:0]      hash_q;
	logic             done_q;
	asta_out_t        rsp_q;

	logic [64:0] diff;
	logic        holds;
	logic        match;
	logic        issue;
	logic        last_cmp;
	logic        fits;
	logic        alloc_new;
	asta_out_t   fin_rsp;
	logic [63:0] fin_bump;
	logic [SLOTS-1:0] fin_live;
	logic [SLOTS-1:0] fin_assigned;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// The compare stage sees the slot base that was read in the previous cycle.
	assign diff  = {1'b0, key_q} - {1'b0, mem_rdata};
	assign holds = !diff[64] && (diff[63:0] < ARENA64);

	always_comb begin
		case (op_q)
			OP_ALLOC:             match = !live_s1;
			OP_FREE, OP_EXACT:    match = live_s1 && (mem_rdata == key_q);
			OP_POOL, OP_OBSERVE:  match = live_s1 && holds;
			default:              match = 1'b0;
		endcase
	end

	assign issue     = (rd_ptr_q < CW'(SLOTS));
	assign last_cmp  = (idx_s1 == IW'(SLOTS - 1));
	assign mem_raddr = rd_ptr_q[IW-1:0];

	assign fits      = !((bump_q + ARENA64) > REGION64);
	assign alloc_new = (state_q == S_FIN) && (op_q == OP_ALLOC) && size_ok_q && hit_q &&
		!assigned_q[hit_idx_q] && fits;
	assign mem_we    = alloc_new;
	assign mem_waddr = hit_idx_q;
	assign mem_wdata = arena_start + bump_q;

	always_comb begin
		fin_rsp                = '0;
		fin_rsp.grants_total   = grant_q;
		fin_rsp.releases_total = release_q;
		fin_rsp.checksum       = hash_q;
		fin_bump               = bump_q;
		fin_live               = live_q;
		fin_assigned           = assigned_q;
		case (op_q)
			OP_ALLOC: begin
				if (!size_ok_q) begin
					fin_rsp.error_code = ERR_ALLOC_SIZE;
				end else if (hit_q && assigned_q[hit_idx_q]) begin
					fin_live[hit_idx_q]    = 1'b1;
					fin_rsp.grants_total   = grant_q + 32'd1;
					fin_rsp.result_address = hit_base_q;
					fin_rsp.found          = 1'b1;
				end else if (hit_q && fits) begin
					fin_live[hit_idx_q]     = 1'b1;
					fin_assigned[hit_idx_q] = 1'b1;
					fin_bump                = bump_q + ARENA64;
					fin_rsp.grants_total    = grant_q + 32'd1;
					fin_rsp.result_address  = mem_wdata;
					fin_rsp.found           = 1'b1;
				end
			end
			OP_FREE: begin
				if (!size_ok_q) begin
					fin_rsp.error_code = ERR_FREE_SIZE;
				end else if (hit_q) begin
					fin_live[hit_idx_q]    = 1'b0;
					fin_rsp.releases_total = release_q + 32'd1;
					fin_rsp.result_address = hit_base_q;
					fin_rsp.found          = 1'b1;
				end else begin
					fin_rsp.error_code = ERR_FREE_MISS;
				end
			end
			OP_EXACT: begin
				if (hit_q) begin
					fin_rsp.result_address = hit_base_q;
					fin_rsp.found          = 1'b1;
				end else begin
					fin_rsp.error_code = ERR_LOOKUP_MISS;
				end
			end
			OP_POOL: begin
				if (hit_q) begin
					fin_rsp.result_address = key_q;
					fin_rsp.found          = 1'b1;
				end
			end
			OP_OBSERVE: begin
				// A null address leaves the checksum alone.
				if (key_q != 64'd0) begin
					fin_rsp.checksum = mul33(hash_q) ^ term_q;
					fin_rsp.found    = hit_q;
				end
			end
			OP_INIT: begin
				fin_bump = (64'd0 - arena_start) & POOL_LOW;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done_q     <= 1'b0;
			vld_s1     <= 1'b0;
			rd_ptr_q   <= '0;
			hit_q      <= 1'b0;
			live_q     <= '0;
			assigned_q <= '0;
			bump_q     <= '0;
			grant_q    <= '0;
			release_q  <= '0;
			hash_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= req.op;
						key_q     <= (req.op == OP_POOL) ? (req.address & ~POOL_LOW) : req.address;
						size13_q  <= mul13(req.size);
						code_q    <= req.event_code;
						size_ok_q <= (req.size == ARENA64);
						hit_q     <= 1'b0;
						rd_ptr_q  <= '0;
						vld_s1    <= 1'b0;
						case (req.op)
							OP_ALLOC, OP_FREE: begin
								state_q <= (req.size == ARENA64) ? S_SCAN : S_FIN;
							end
							OP_EXACT, OP_POOL: begin
								state_q <= S_SCAN;
							end
							OP_OBSERVE: begin
								state_q <= (req.address != 64'd0) ? S_SCAN : S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (vld_s1 && (match || last_cmp)) begin
						hit_q      <= match;
						hit_idx_q  <= idx_s1;
						hit_base_q <= mem_rdata;
						diff_q     <= diff[63:0];
						hit_ofs_q  <= 32'(idx_s1) * ARENA32;
						vld_s1     <= 1'b0;
						state_q    <= (op_q == OP_OBSERVE) ? S_LOC : S_FIN;
					end else begin
						vld_s1 <= issue;
						if (issue) begin
							idx_s1   <= rd_ptr_q[IW-1:0];
							live_s1  <= live_q[rd_ptr_q[IW-1:0]];
							rd_ptr_q <= rd_ptr_q + CW'(1);
						end
					end
				end
				S_LOC: begin
					loc_q   <= hit_q ? ({32'd0, hit_ofs_q} + diff_q)
						: (key_q - metadata_start + REGION64);
					state_q <= S_TERM;
				end
				S_TERM: begin
					term_q  <= loc_q + size13_q + {32'd0, code_q};
					state_q <= S_FIN;
				end
				S_FIN: begin
					live_q     <= fin_live;
					assigned_q <= fin_assigned;
					bump_q     <= fin_bump;
					grant_q    <= fin_rsp.grants_total;
					release_q  <= fin_rsp.releases_total;
					hash_q     <= fin_rsp.checksum;
					rsp_q      <= fin_rsp;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_write_only_on_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_FIN && op_q == OP_ALLOC))
		else $error("slot table written outside an alloc");

	a_live_is_assigned: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q & ~assigned_q) == '0)
		else $error("live slot that was never assigned");

	a_assigned_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((assigned_q & $past(assigned_q)) == $past(assigned_q)))
		else $error("assigned slot lost its mark");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_FIN) |=> ($stable(grant_q) && $stable(release_q)))
		else $error("counters moved outside the finish step");

endmodule

[design/arena_slot_table_allocator_unit.sv]
// Channel   Handshake               Payload
// request   start high, busy low    req  (asta_in_t)
// result    done, one cycle         rsp  (asta_out_t)
// config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
// Requests that search the table walk the slot memory one entry per cycle through its
// single read port, and observe then passes through the checksum steps S_LOC and S_TERM.
// Requests that need no walk go straight from idle to the finish step.
// Reset clears all slot marks, counters and the checksum at once; no clearing pass.
// The result is shown for one cycle on done, and the receiver cannot stall it; a new
// request may start in that cycle.
// Configuration is always ready, and a written value is used from then on, also by a request already in flight.
module arena_slot_table_allocator_unit #(
	parameter int unsigned     SLOTS        = 32,
	parameter longint unsigned REGION_BYTES = 64'd33554432,
	parameter longint unsigned ARENA_BYTES  = 64'd1048576,
	parameter longint unsigned POOL_BYTES   = 64'd16384
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  asta_pkg::asta_in_t                req,
	output logic                              done,
	output asta_pkg::asta_out_t               rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [asta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                       cfg_data
);
	import asta_pkg::*;

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [63:0]   arena_start_q;
	logic [63:0]   metadata_start_q;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [63:0]   mem_wdata;
	logic [IW-1:0] mem_raddr;
	logic [63:0]   mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_start_q    <= '0;
			metadata_start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ARENA_START:    arena_start_q    <= cfg_data;
				CFG_METADATA_START: metadata_start_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	asta_slot_ram #(
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	asta_ctrl #(
		.SLOTS        (SLOTS),
		.REGION_BYTES (REGION_BYTES),
		.ARENA_BYTES  (ARENA_BYTES),
		.POOL_BYTES   (POOL_BYTES),
		.IW           (IW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req            (req),
		.done           (done),
		.rsp            (rsp),
		.arena_start    (arena_start_q),
		.metadata_start (metadata_start_q),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

endmodule
